>>> rtl/mise_pkg.sv
// Shared types and constants for the mesh isocline segment extractor.
// No dependencies; every other file in rtl/ depends on this package.
`timescale 1ns / 1ps
`default_nettype none
package mise_pkg;

    localparam int DIR_W     = 16;
    localparam int THR_W     = 21;
    localparam int A_FRAC    = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_DIR_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_Z = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_THR   = 2'd3;

    localparam logic signed [DIR_W-1:0] DIR_X_RST = 16'sd0;
    localparam logic signed [DIR_W-1:0] DIR_Y_RST = 16'sd0;
    localparam logic signed [DIR_W-1:0] DIR_Z_RST = 16'sd16384;
    localparam logic [THR_W-1:0]        THR_RST   = 21'd27;

    typedef struct packed {
        logic signed [DIR_W-1:0] dir_x;
        logic signed [DIR_W-1:0] dir_y;
        logic signed [DIR_W-1:0] dir_z;
        logic [THR_W-1:0]        thr;
    } t_cfg;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EDGE,
        S_DIV,
        S_MUL,
        S_ACC,
        S_OUT
    } t_back_state;

endpackage
`default_nettype wire

>>> rtl/mise_if.sv
// Handshake interfaces: vertex input, segment output and configuration write.
// Depends on mise_pkg for the configuration field widths.
`timescale 1ns / 1ps
`default_nettype none
interface mise_vtx_if #(parameter int PW = 24, parameter int NW = 16);
    logic                 valid;
    logic                 ready;
    logic signed [PW-1:0] pos_x;
    logic signed [PW-1:0] pos_y;
    logic signed [PW-1:0] pos_z;
    logic signed [NW-1:0] nrm_x;
    logic signed [NW-1:0] nrm_y;
    logic signed [NW-1:0] nrm_z;
    logic                 nrm_invalid;
    modport source (output valid, pos_x, pos_y, pos_z, nrm_x, nrm_y, nrm_z, nrm_invalid,
                    input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, nrm_x, nrm_y, nrm_z, nrm_invalid,
                    output ready);
endinterface

interface mise_seg_if #(parameter int PW = 24, parameter int NW = 16);
    logic                 valid;
    logic                 ready;
    logic signed [PW-1:0] seg_start_x;
    logic signed [PW-1:0] seg_start_y;
    logic signed [PW-1:0] seg_start_z;
    logic signed [NW-1:0] seg_start_nx;
    logic signed [NW-1:0] seg_start_ny;
    logic signed [NW-1:0] seg_start_nz;
    logic signed [PW-1:0] seg_end_x;
    logic signed [PW-1:0] seg_end_y;
    logic signed [PW-1:0] seg_end_z;
    logic signed [NW-1:0] seg_end_nx;
    logic signed [NW-1:0] seg_end_ny;
    logic signed [NW-1:0] seg_end_nz;
    modport source (output valid, seg_start_x, seg_start_y, seg_start_z, seg_start_nx,
                    seg_start_ny, seg_start_nz, seg_end_x, seg_end_y, seg_end_z,
                    seg_end_nx, seg_end_ny, seg_end_nz, input ready);
    modport sink   (input valid, seg_start_x, seg_start_y, seg_start_z, seg_start_nx,
                    seg_start_ny, seg_start_nz, seg_end_x, seg_end_y, seg_end_z,
                    seg_end_nx, seg_end_ny, seg_end_nz, output ready);
endinterface

interface mise_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [mise_pkg::CFG_IDX_W-1:0]    index;
    logic [mise_pkg::THR_W-1:0]        data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> rtl/mise_front.sv
// Front end: collects three vertices into a face, forms the three dot products
// and hands valid faces to the queue. Depends on mise_pkg and mise_if.
`timescale 1ns / 1ps
`default_nettype none
module mise_front #(
    parameter int PW = 24,
    parameter int NW = 16,
    parameter int DW = NW + mise_pkg::DIR_W + 2
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    mise_vtx_if.sink                           i_vtx,
    input  wire mise_pkg::t_cfg                i_cfg,
    output logic                               o_push,
    input  wire logic                          i_push_ready,
    output logic [9*PW+9*NW+3*DW-1:0]          o_face
);
    import mise_pkg::*;

    localparam int PRW = NW + DIR_W;

    logic [1:0]                 r_cnt;
    logic                       r_inv;
    logic [8:0][PW-1:0]         r_pos;
    logic [8:0][NW-1:0]         r_nrm;
    logic [2:0][DW-1:0]         r_dot;
    logic                       r_pv;
    logic [1:0]                 r_pslot;
    logic signed [PRW-1:0]      r_prod [3];
    logic                       r_push;
    logic                       acc;
    logic signed [DW-1:0]       dot_sum;

    assign i_vtx.ready = !r_push && !(r_pv && (r_pslot == 2'd2));
    assign acc         = i_vtx.valid && i_vtx.ready;
    assign o_push      = r_push;
    assign o_face      = {r_dot, r_nrm, r_pos};
    assign dot_sum     = DW'(r_prod[0]) + DW'(r_prod[1]) + DW'(r_prod[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= 2'd0;
            r_pv   <= 1'b0;
            r_push <= 1'b0;
        end else begin
            r_pv <= acc;
            if (acc) begin
                r_cnt <= (r_cnt == 2'd2) ? 2'd0 : r_cnt + 2'd1;
            end
            if (r_pv && (r_pslot == 2'd2) && !r_inv) begin
                r_push <= 1'b1;
            end else if (i_push_ready) begin
                r_push <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_pos[4'(r_cnt) * 4'd3]        <= i_vtx.pos_x;
            r_pos[4'(r_cnt) * 4'd3 + 4'd1] <= i_vtx.pos_y;
            r_pos[4'(r_cnt) * 4'd3 + 4'd2] <= i_vtx.pos_z;
            r_nrm[4'(r_cnt) * 4'd3]        <= i_vtx.nrm_x;
            r_nrm[4'(r_cnt) * 4'd3 + 4'd1] <= i_vtx.nrm_y;
            r_nrm[4'(r_cnt) * 4'd3 + 4'd2] <= i_vtx.nrm_z;
            r_inv     <= (r_cnt == 2'd0) ? i_vtx.nrm_invalid : (r_inv | i_vtx.nrm_invalid);
            r_pslot   <= r_cnt;
            r_prod[0] <= i_vtx.nrm_x * i_cfg.dir_x;
            r_prod[1] <= i_vtx.nrm_y * i_cfg.dir_y;
            r_prod[2] <= i_vtx.nrm_z * i_cfg.dir_z;
        end
        if (r_pv) begin
            r_dot[r_pslot] <= dot_sum;
        end
    end

endmodule
`default_nettype wire

>>> rtl/mise_fifo.sv
// Two-entry queue of face records between the front and the back end.
// Depends on mise_pkg only by house convention.
`timescale 1ns / 1ps
`default_nettype none
module mise_fifo #(
    parameter int W = 8
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire logic [W-1:0] i_data,
    output logic              o_ready,
    input  wire logic         i_pop,
    output logic              o_valid,
    output logic [W-1:0]      o_data
);
    import mise_pkg::*;

    logic [W-1:0] r_mem [2];
    logic         r_wp;
    logic         r_rp;
    logic [1:0]   r_cnt;
    logic         do_push;
    logic         do_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) begin
                r_wp <= ~r_wp;
            end
            if (do_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(do_push) - 2'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule
`default_nettype wire

>>> rtl/mise_div.sv
// Restoring divider for the crossing parameter: one quotient bit per cycle.
// Requires num <= den; the quotient has A_FRAC fraction bits. Depends on mise_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mise_div #(
    parameter int DEN_W = 35
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic [DEN_W-1:0]          i_num,
    input  wire logic [DEN_W-1:0]          i_den,
    output mise_pkg::t_div_status          o_status,
    output logic [mise_pkg::A_FRAC:0]      o_quot
);
    import mise_pkg::*;

    localparam int QW = A_FRAC + 1;
    localparam int CW = $clog2(QW + 1);

    logic             r_busy;
    logic             r_done;
    logic [CW-1:0]    r_cnt;
    logic [DEN_W:0]   r_rem;
    logic [DEN_W-1:0] r_den;
    logic [QW-1:0]    r_q;
    logic             qbit;
    logic [DEN_W:0]   rem_sub;

    assign qbit    = (r_rem >= {1'b0, r_den});
    assign rem_sub = qbit ? (r_rem - {1'b0, r_den}) : r_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(QW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // The remainder stays below den after each step, so doubling needs one extra bit.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= {1'b0, i_num};
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= {rem_sub[DEN_W-1:0], 1'b0};
            r_q   <= {r_q[QW-2:0], qbit};
        end
    end

    assign o_status.busy = r_busy;
    assign o_status.done = r_done;
    assign o_quot        = r_q;

endmodule
`default_nettype wire

>>> rtl/mise_back.sv
// Back end: walks the edges of a queued face in turn, finds crossings with the divider
// (or from the start dot product alone when the dot difference is within the threshold),
// interpolates with one multiplier and emits the segment. Depends on mise_pkg, mise_if, mise_div.
`timescale 1ns / 1ps
`default_nettype none
module mise_back #(
    parameter int PW = 24,
    parameter int NW = 16,
    parameter int DW = NW + mise_pkg::DIR_W + 2
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_face_valid,
    input  wire logic [9*PW+9*NW+3*DW-1:0]     i_face,
    output logic                               o_pop,
    input  wire mise_pkg::t_cfg                i_cfg,
    mise_seg_if.source                         o_seg
);
    import mise_pkg::*;

    localparam int DEN_W    = DW + 1;
    localparam int DOT_FRAC = NW - 2 + DIR_W - 2;
    localparam int QW       = A_FRAC + 1;
    // Positions and normals share one interpolation path as wide as the wider of the two.
    localparam int EW       = (PW > NW) ? PW : NW;
    localparam int TW       = EW + 19;
    localparam logic [DEN_W-1:0] NEAR_LIM = DEN_W'(1) << DOT_FRAC;

    t_back_state                r_state;
    t_back_state                n_state;
    logic [8:0][PW-1:0]         r_pos;
    logic [8:0][NW-1:0]         r_nrm;
    logic [2:0][DW-1:0]         r_dot;
    logic [1:0]                 r_edge;
    logic [1:0]                 r_found;
    logic [2:0]                 r_k;
    logic [QW-1:0]              r_a;
    logic signed [EW-1:0]       r_e0 [6];
    logic signed [EW-1:0]       r_e1 [6];
    logic signed [TW-1:0]       r_prod;
    logic [1:0][5:0][EW-1:0]    r_pt;
    logic                       r_ovld;

    logic signed [DW-1:0]       d0;
    logic signed [DW-1:0]       d1;
    logic signed [EW-1:0]       s0 [6];
    logic signed [EW-1:0]       s1 [6];
    logic signed [DEN_W-1:0]    diff;
    logic signed [DEN_W-1:0]    num_near;
    logic [DEN_W-1:0]           adiff;
    logic [DEN_W-1:0]           num_div;
    logic                       divide;
    logic                       ok_div;
    logic                       ok_near;
    logic                       edge_ok;
    logic                       last_edge;
    logic                       div_start;
    t_div_status                div_st;
    logic [QW-1:0]              div_q;
    logic signed [EW:0]         delta;
    logic signed [TW-1:0]       acc_t;

    mise_div #(.DEN_W(DEN_W)) u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (div_start),
        .i_num    (num_div),
        .i_den    (adiff),
        .o_status (div_st),
        .o_quot   (div_q)
    );

    // Edge endpoint selection: edges 0-1, 1-2, then 2-0.
    always_comb begin
        d0 = $signed(r_dot[0]);
        d1 = $signed(r_dot[1]);
        for (int k = 0; k < 3; k++) begin
            s0[k] = EW'($signed(r_pos[k]));      s1[k] = EW'($signed(r_pos[3 + k]));
            s0[3 + k] = EW'($signed(r_nrm[k]));
            s1[3 + k] = EW'($signed(r_nrm[3 + k]));
        end
        unique case (r_edge)
            2'd1: begin
                d0 = $signed(r_dot[1]);
                d1 = $signed(r_dot[2]);
                for (int k = 0; k < 3; k++) begin
                    s0[k] = EW'($signed(r_pos[3 + k]));  s1[k] = EW'($signed(r_pos[6 + k]));
                    s0[3 + k] = EW'($signed(r_nrm[3 + k]));
                    s1[3 + k] = EW'($signed(r_nrm[6 + k]));
                end
            end
            2'd2: begin
                d0 = $signed(r_dot[2]);
                d1 = $signed(r_dot[0]);
                for (int k = 0; k < 3; k++) begin
                    s0[k] = EW'($signed(r_pos[6 + k]));  s1[k] = EW'($signed(r_pos[k]));
                    s0[3 + k] = EW'($signed(r_nrm[6 + k]));
                    s1[3 + k] = EW'($signed(r_nrm[k]));
                end
            end
            default: begin
            end
        endcase
    end

    assign diff     = DEN_W'(d1) - DEN_W'(d0);
    assign num_near = -DEN_W'(d0);
    assign adiff    = diff[DEN_W-1] ? DEN_W'(-diff) : DEN_W'(diff);
    assign num_div  = diff[DEN_W-1] ? DEN_W'(DEN_W'(d0)) : DEN_W'(num_near);
    assign divide   = (adiff > DEN_W'(i_cfg.thr));
    assign ok_div   = !num_div[DEN_W-1] && (num_div <= adiff);
    assign ok_near  = !num_near[DEN_W-1] && (DEN_W'(num_near) <= NEAR_LIM);
    assign edge_ok  = divide ? ok_div : ok_near;
    assign last_edge = (r_edge == 2'd2);

    assign delta = (EW + 1)'(r_e1[r_k]) - (EW + 1)'(r_e0[r_k]);
    assign acc_t = {{3{r_e0[r_k][EW-1]}}, r_e0[r_k], A_FRAC'(0)} + r_prod
                 + TW'(1 << (A_FRAC - 1));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_face_valid) begin
                    n_state = S_EDGE;
                end
            end
            S_EDGE: begin
                if (edge_ok) begin
                    n_state = divide ? S_DIV : S_MUL;
                end else if (last_edge) begin
                    n_state = (r_found != 2'd0) ? S_OUT : S_IDLE;
                end
            end
            S_DIV: begin
                if (div_st.done) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: n_state = S_ACC;
            S_ACC: begin
                if (r_k != 3'd5) begin
                    n_state = S_MUL;
                end else if (r_found == 2'd1 || last_edge) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_EDGE;
                end
            end
            S_OUT: begin
                if (!r_ovld) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_pop     = (r_state == S_IDLE) && i_face_valid;
        div_start = (r_state == S_EDGE) && divide && ok_div;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ovld  <= 1'b0;
            r_found <= 2'd0;
            r_edge  <= 2'd0;
        end else begin
            r_state <= n_state;
            if (r_state == S_OUT && !r_ovld) begin
                r_ovld <= 1'b1;
            end else if (o_seg.ready) begin
                r_ovld <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    r_found <= 2'd0;
                    r_edge  <= 2'd0;
                end
                S_EDGE: begin
                    if (!edge_ok && !last_edge) begin
                        r_edge <= r_edge + 2'd1;
                    end
                end
                S_ACC: begin
                    if (r_k == 3'd5) begin
                        r_found <= r_found + 2'd1;
                        if (!last_edge) begin
                            r_edge <= r_edge + 2'd1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            {r_dot, r_nrm, r_pos} <= i_face;
        end
        if (r_state == S_EDGE) begin
            r_e0 <= s0;
            r_e1 <= s1;
            r_k  <= 3'd0;
            r_a  <= num_near[DOT_FRAC -: QW];
        end
        if (div_st.done) begin
            r_a <= div_q;
        end
        if (r_state == S_MUL) begin
            r_prod <= $signed({1'b0, r_a}) * delta;
        end
        if (r_state == S_ACC) begin
            r_pt[r_found[0]][r_k] <= acc_t[A_FRAC +: EW];
            r_k <= r_k + 3'd1;
        end
        if (r_state == S_OUT && !r_ovld) begin
            o_seg.seg_start_x  <= r_pt[0][0][PW-1:0];
            o_seg.seg_start_y  <= r_pt[0][1][PW-1:0];
            o_seg.seg_start_z  <= r_pt[0][2][PW-1:0];
            o_seg.seg_start_nx <= r_pt[0][3][NW-1:0];
            o_seg.seg_start_ny <= r_pt[0][4][NW-1:0];
            o_seg.seg_start_nz <= r_pt[0][5][NW-1:0];
            o_seg.seg_end_x    <= r_pt[r_found[1]][0][PW-1:0];
            o_seg.seg_end_y    <= r_pt[r_found[1]][1][PW-1:0];
            o_seg.seg_end_z    <= r_pt[r_found[1]][2][PW-1:0];
            o_seg.seg_end_nx   <= r_pt[r_found[1]][3][NW-1:0];
            o_seg.seg_end_ny   <= r_pt[r_found[1]][4][NW-1:0];
            o_seg.seg_end_nz   <= r_pt[r_found[1]][5][NW-1:0];
        end
    end

    assign o_seg.valid = r_ovld;

    a_found_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_found != 2'd3)
        else $error("more than two crossings recorded");
    a_div_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_st.busy |-> (r_state == S_DIV))
        else $error("divider running outside the divide state");
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && !r_ovld) |=> r_ovld)
        else $error("segment not loaded into output register");

endmodule
`default_nettype wire

>>> rtl/mesh_isocline_segment_extractor.sv
// A face completed by its last vertex beat passes through the front end and the queue;
// the back end then tries the edges in turn, runs the divider where a crossing needs it,
// interpolates six components per crossing (a multiply, then an accumulate step each)
// and loads the output register. Vertex input takes three beats per face, then holds
// ready low while the face is pushed; a two-face queue lets loading overlap that work.
// Reset (synchronous, active low) clears control state and loads default register values.
`timescale 1ns / 1ps
`default_nettype none
module mesh_isocline_segment_extractor #(
    parameter int POS_WIDTH = 24,
    parameter int NRM_WIDTH = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    mise_vtx_if.sink  i_vtx,
    mise_seg_if.source o_seg,
    mise_cfg_if.sink  i_cfg
);
    import mise_pkg::*;

    localparam int DW     = NRM_WIDTH + DIR_W + 2;
    localparam int FACE_W = 9 * POS_WIDTH + 9 * NRM_WIDTH + 3 * DW;

    t_cfg              r_cfg;
    logic              push;
    logic              push_ready;
    logic [FACE_W-1:0] face_in;
    logic              face_valid;
    logic [FACE_W-1:0] face_out;
    logic              pop;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dir_x <= DIR_X_RST;
            r_cfg.dir_y <= DIR_Y_RST;
            r_cfg.dir_z <= DIR_Z_RST;
            r_cfg.thr   <= THR_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_DIR_X: r_cfg.dir_x <= i_cfg.data[DIR_W-1:0];
                CFG_DIR_Y: r_cfg.dir_y <= i_cfg.data[DIR_W-1:0];
                CFG_DIR_Z: r_cfg.dir_z <= i_cfg.data[DIR_W-1:0];
                CFG_THR:   r_cfg.thr   <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    mise_front #(.PW(POS_WIDTH), .NW(NRM_WIDTH), .DW(DW)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_vtx        (i_vtx),
        .i_cfg        (r_cfg),
        .o_push       (push),
        .i_push_ready (push_ready),
        .o_face       (face_in)
    );

    mise_fifo #(.W(FACE_W)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (face_in),
        .o_ready (push_ready),
        .i_pop   (pop),
        .o_valid (face_valid),
        .o_data  (face_out)
    );

    mise_back #(.PW(POS_WIDTH), .NW(NRM_WIDTH), .DW(DW)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_face_valid (face_valid),
        .i_face       (face_out),
        .o_pop        (pop),
        .i_cfg        (r_cfg),
        .o_seg        (o_seg)
    );

endmodule
`default_nettype wire
